/* rtl/core/nfba_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and control types of the next-fit slot allocator.
// No dependencies; every other file of the block imports this package.
package nfba_pkg;

   // Slot map geometry. SLOTS is a multiple of WORD_W.
   localparam int SLOTS      = 1024;
   localparam int SLOT_W     = $clog2(SLOTS);
   localparam int POOL_W     = SLOT_W + 1;
   localparam int WORD_W     = 32;
   localparam int BIT_W      = $clog2(WORD_W);
   localparam int WORDS      = SLOTS / WORD_W;
   localparam int WIDX_W     = $clog2(WORDS);
   localparam int VISIT_W    = $clog2(WORDS + 2);
   localparam int MODCNT_W   = $clog2(POOL_W + 1);

   localparam logic [POOL_W-1:0] POOL_RESET = POOL_W'(SLOTS);
   localparam logic [SLOT_W-1:0] LAST_RESET = SLOT_W'(SLOTS - 1);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DECODE = 6'b000010,
      ST_MOD    = 6'b000100,
      ST_READ   = 6'b001000,
      ST_EVAL   = 6'b010000,
      ST_DONE   = 6'b100000
   } ctl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic idle;
      logic range_fail;
      logic start_direct;
      logic mod_init;
      logic mod_step;
      logic read;
      logic eval;
      logic push;
   } nfba_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic op_free;
      logic idx_oor;
      logic need_mod;
      logic mod_last;
      logic hit;
      logic scan_end;
      logic out_free;
   } nfba_sts_type;

endpackage

/* rtl/core/nfba_if.sv */
`timescale 1ns / 1ps
// Handshake channels of the slot allocator: request, response and pool size write.
// Depends on nfba_pkg for the field widths.
interface nfba_req_if import nfba_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              operation;
   logic [SLOT_W-1:0] slot_index;
   modport source (output valid, output operation, output slot_index, input ready);
   modport sink   (input valid, input operation, input slot_index, output ready);
endinterface

interface nfba_rsp_if import nfba_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] granted_slot;
   logic [1:0]        status;
   modport source (output valid, output granted_slot, output status, input ready);
   modport sink   (input valid, input granted_slot, input status, output ready);
endinterface

interface nfba_csr_if import nfba_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [POOL_W-1:0] pool_size;
   modport source (output valid, output pool_size, input ready);
   modport sink   (input valid, input pool_size, output ready);
endinterface

/* rtl/core/next_fit_bitmap_slot_allocator.sv */
`timescale 1ns / 1ps
// Next-fit slot allocator. One word in flight: an in-range free reads and rewrites one map
// word, an out-of-range free replies without a map access; allocate visits 1 to 33 map words
// in turn (32 slots a word, one map memory read per word), after a bit-serial modulo of the
// start when the last grant lies at or above the pool size. A new word is accepted the
// cycle after the reply is loaded, later while an older reply waits on the sink.
// Synchronous reset clears the map at once through per-word valid bits.
module next_fit_bitmap_slot_allocator import nfba_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   nfba_req_if.sink   req_chan,
   nfba_rsp_if.source rsp_chan,
   nfba_csr_if.sink   csr_chan
);

   // Controller decides the sequence; the datapath holds the data registers and the map.
   nfba_cmd_type ctl_cmd;
   nfba_sts_type dp_sts;

   nfba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .sts       (dp_sts),
      .cmd       (ctl_cmd)
   );

   // Map memory, scan, start reduction and the response register that lets the
   // sink stall without holding up the next request.
   nfba_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan),
      .cmd      (ctl_cmd),
      .sts      (dp_sts)
   );

`ifndef ASSERT_OFF
   // Only a successful grant carries a non-zero slot
   a_zero_slot_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status != STATUS_OK)) |-> (rsp_chan.granted_slot == '0))
      else $error("non-zero slot on a failed reply");

   // Drop ready once a word is taken, until its reply is loaded
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("second word accepted while one is in flight");

   // A reply appears only out of work on an accepted word
   a_reply_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> !$past(req_chan.ready))
      else $error("reply raised while idle");
`endif

endmodule

/* rtl/core/nfba_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer of the slot allocator: walks decode, start reduction, word scan and reply.
// Depends on nfba_pkg; drives nfba_dpath through nfba_cmd_type.
module nfba_ctrl import nfba_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  nfba_sts_type sts,
   output nfba_cmd_type cmd
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.idle = 1'b1;
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.op_free) begin
               if (sts.idx_oor) begin
                  cmd.range_fail = 1'b1;
                  state_in       = ST_DONE;
               end else begin
                  cmd.read = 1'b1;
                  state_in = ST_EVAL;
               end
            end else if (sts.need_mod) begin
               cmd.mod_init = 1'b1;
               state_in     = ST_MOD;
            end else begin
               cmd.start_direct = 1'b1;
               state_in         = ST_READ;
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.op_free || sts.hit || sts.scan_end) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/nfba_dpath.sv */
`timescale 1ns / 1ps
// Datapath of the slot allocator: used-bit map memory, next-fit scan, start modulo
// unit, pool size register and response register. Depends on nfba_pkg and nfba_if.
module nfba_dpath import nfba_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   nfba_req_if.sink     req_chan,
   nfba_rsp_if.source   rsp_chan,
   nfba_csr_if.sink     csr_chan,
   input  nfba_cmd_type cmd,
   output nfba_sts_type sts
);

   // request and configuration
   logic                op_ff;
   logic [SLOT_W-1:0]   idx_ff;
   logic [POOL_W-1:0]   pool_ff;
   logic [SLOT_W-1:0]   last_ff;

   // start reduction
   logic [POOL_W-1:0]   mod_r_ff;
   logic [POOL_W-1:0]   mod_d_ff;
   logic [MODCNT_W-1:0] mod_cnt_ff;
   logic [POOL_W-1:0]   mod_shift;
   logic [POOL_W-1:0]   mod_r_in;

   // scan
   logic [SLOT_W-1:0]   start_ff;
   logic [WIDX_W-1:0]   wd_ff;
   logic [VISIT_W-1:0]  visits_ff;

   // map
   logic [WORD_W-1:0]   map_mem [WORDS];
   logic [WORDS-1:0]    map_vld_ff;
   logic [WORD_W-1:0]   rd_data_ff;
   logic                rd_vld_ff;

   // result
   logic [SLOT_W-1:0]   res_slot_ff;
   status_type          res_status_ff;
   logic                rsp_valid_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   status_type          rsp_status_ff;

   logic                accept;
   logic [POOL_W-1:0]   eff_pool;
   logic [POOL_W-1:0]   eff_m1;
   logic [POOL_W-1:0]   last_inc;
   logic [WIDX_W-1:0]   last_word;
   logic [VISIT_W-1:0]  word_count;
   logic                load_start;
   logic [SLOT_W-1:0]   start_val;
   logic [WIDX_W-1:0]   map_addr;
   logic [WORD_W-1:0]   word;
   logic [WORD_W-1:0]   free_vec;
   logic [BIT_W-1:0]    hit_pos;
   logic                hit;
   logic [WORD_W-1:0]   hit_onehot;
   logic [WORD_W-1:0]   idx_onehot;
   logic                map_we;
   logic [WORD_W-1:0]   map_wdata;
   logic [SLOT_W-1:0]   grant;

   assign accept   = req_chan.valid & cmd.idle;
   assign req_chan.ready = cmd.idle;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      if (pool_ff == '0) begin
         eff_pool = POOL_W'(1);
      end else if (pool_ff > POOL_W'(SLOTS)) begin
         eff_pool = POOL_W'(SLOTS);
      end else begin
         eff_pool = pool_ff;
      end
   end

   assign eff_m1     = eff_pool - POOL_W'(1);
   assign last_inc   = {1'b0, last_ff} + POOL_W'(1);
   assign last_word  = eff_m1[SLOT_W-1:BIT_W];
   assign word_count = VISIT_W'(last_word) + VISIT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff <= POOL_RESET;
      end else if (csr_chan.valid) begin
         pool_ff <= csr_chan.pool_size;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_chan.operation;
         idx_ff <= req_chan.slot_index;
      end
   end

   // Restoring remainder of (last granted + 1) by the pool, one bit a cycle
   assign mod_shift = {mod_r_ff[POOL_W-2:0], mod_d_ff[POOL_W-1]};
   assign mod_r_in  = (mod_shift >= eff_pool) ? (mod_shift - eff_pool) : mod_shift;

   always_ff @(posedge clock) begin
      if (cmd.mod_init) begin
         mod_r_ff   <= '0;
         mod_d_ff   <= last_inc;
         mod_cnt_ff <= MODCNT_W'(POOL_W);
      end else if (cmd.mod_step) begin
         mod_r_ff   <= mod_r_in;
         mod_d_ff   <= {mod_d_ff[POOL_W-2:0], 1'b0};
         mod_cnt_ff <= mod_cnt_ff - MODCNT_W'(1);
      end
   end

   always_comb begin
      load_start = cmd.start_direct | (cmd.mod_step & sts.mod_last);
      if (cmd.mod_step) begin
         start_val = mod_r_in[SLOT_W-1:0];
      end else if (last_inc == eff_pool) begin
         start_val = '0;
      end else begin
         start_val = last_inc[SLOT_W-1:0];
      end
   end

   // Word under test: free bits at or after the start on the first visit, inside the pool
   assign map_addr = (op_ff == OP_FREE) ? idx_ff[SLOT_W-1:BIT_W] : wd_ff;
   assign word     = rd_vld_ff ? rd_data_ff : '0;

   always_comb begin
      for (int i = 0; i < WORD_W; i++) begin
         free_vec[i] = ~word[i]
                     & ((visits_ff != '0) || (BIT_W'(i) >= start_ff[BIT_W-1:0]))
                     & ((wd_ff != last_word) || (BIT_W'(i) <= eff_m1[BIT_W-1:0]));
      end
   end

   always_comb begin
      hit_pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            hit_pos = BIT_W'(i);
         end
      end
   end

   assign hit        = |free_vec;
   assign hit_onehot = WORD_W'(1) << hit_pos;
   assign idx_onehot = WORD_W'(1) << idx_ff[BIT_W-1:0];
   assign grant      = {wd_ff, hit_pos};
   assign map_we     = cmd.eval & ((op_ff == OP_FREE) | hit);
   assign map_wdata  = (op_ff == OP_FREE) ? (word & ~idx_onehot) : (word | hit_onehot);

   always_ff @(posedge clock) begin
      if (load_start) begin
         start_ff  <= start_val;
         wd_ff     <= start_val[SLOT_W-1:BIT_W];
         visits_ff <= '0;
      end else if (cmd.eval && !hit) begin
         wd_ff     <= (wd_ff == last_word) ? '0 : (wd_ff + WIDX_W'(1));
         visits_ff <= visits_ff + VISIT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_data_ff <= map_mem[map_addr];
         rd_vld_ff  <= map_vld_ff[map_addr];
      end
      if (map_we) begin
         map_mem[map_addr] <= map_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_vld_ff <= '0;
      end else if (map_we) begin
         map_vld_ff[map_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= LAST_RESET;
      end else if (cmd.eval && (op_ff == OP_ALLOC) && hit) begin
         last_ff <= grant;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.range_fail) begin
         res_slot_ff   <= '0;
         res_status_ff <= STATUS_RANGE;
      end else if (cmd.eval) begin
         res_slot_ff   <= ((op_ff == OP_ALLOC) && hit) ? grant : '0;
         res_status_ff <= ((op_ff == OP_FREE) || hit) ? STATUS_OK : STATUS_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_slot_ff   <= res_slot_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.granted_slot = rsp_slot_ff;
   assign rsp_chan.status       = rsp_status_ff;

   assign sts.op_free  = (op_ff == OP_FREE);
   assign sts.idx_oor  = ({1'b0, idx_ff} >= eff_pool);
   assign sts.need_mod = (last_inc > eff_pool);
   assign sts.mod_last = (mod_cnt_ff == MODCNT_W'(1));
   assign sts.hit      = hit;
   assign sts.scan_end = (visits_ff == word_count);
   assign sts.out_free = ~rsp_valid_ff | rsp_chan.ready;

endmodule

/* tb/sv/nfba_reply_checker.sv */
`timescale 1ns / 1ps
// Reply checker of the next-fit slot allocator: watches the request, reply and pool size
// channels, predicts every reply from its own slot map and compares. Depends on nfba_pkg.
module nfba_reply_checker import nfba_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_operation,
   input  logic [SLOT_W-1:0] req_slot_index,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [SLOT_W-1:0] rsp_granted_slot,
   input  logic [1:0]        rsp_status,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [POOL_W-1:0] csr_pool_size,
   output int                failures,
   output int                backlog
);

   typedef struct {
      logic [SLOT_W-1:0] slot;
      status_type        status;
   } reply_type;

   logic              slot_used [SLOTS];
   logic [SLOT_W-1:0] last_grant;
   logic [POOL_W-1:0] pool_size;
   reply_type         pending_replies [$];

   // Apply one request to the map and return the reply it earns.
   function automatic reply_type next_fit_reply(input logic op, input logic [SLOT_W-1:0] idx);
      reply_type r;
      int        n;
      int        pos;
      int        k;
      bit        found;
      n = (pool_size == 0) ? 1 : ((pool_size > SLOTS) ? SLOTS : int'(pool_size));
      r.slot = '0;
      found  = 1'b0;
      if (op == OP_ALLOC) begin
         r.status = STATUS_FULL;
         pos = (int'(last_grant) + 1) % n;
         for (k = 0; k < n && !found; k++) begin
            if (!slot_used[pos]) begin
               slot_used[pos] = 1'b1;
               last_grant     = SLOT_W'(pos);
               r.slot         = SLOT_W'(pos);
               r.status       = STATUS_OK;
               found          = 1'b1;
            end else begin
               pos = (pos + 1 >= n) ? 0 : pos + 1;
            end
         end
      end else if (int'(idx) >= n) begin
         r.status = STATUS_RANGE;
      end else begin
         slot_used[idx] = 1'b0;
         r.status       = STATUS_OK;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         pool_size  = POOL_RESET;
         last_grant = LAST_RESET;
         pending_replies.delete();
         failures = 0;
         backlog <= 0;
      end else begin
         if (csr_valid && csr_ready)
            pool_size = csr_pool_size;
         if (req_valid && req_ready)
            pending_replies.push_back(next_fit_reply(req_operation, req_slot_index));
         if (rsp_valid && rsp_ready) begin
            if (pending_replies.size() == 0) begin
               failures++;
               $error("reply word with no request outstanding: granted_slot %0d status %0d",
                      rsp_granted_slot, rsp_status);
            end else begin
               want = pending_replies.pop_front();
               if (rsp_granted_slot !== want.slot) begin
                  failures++;
                  $error("granted_slot: expected %0d, got %0d", want.slot, rsp_granted_slot);
               end
               if (rsp_status !== want.status) begin
                  failures++;
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
               end
            end
         end
         backlog <= pending_replies.size();
      end
   end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Top of the slot allocator bench: clock, reset, request and pool size stimulus, reply
// back-pressure and the verdict. Depends on nfba_pkg, nfba_if and nfba_reply_checker.
module testbench import nfba_pkg::*; ();

   localparam int RANDOM_ITEMS  = 600;
   localparam int HOLD_CYCLES   = 400;     // long reply hold-off, fills the block
   localparam int SETTLE_CYCLES = 100;     // longer than a full scan plus modulo
   localparam int CYCLE_LIMIT   = 500_000;

   logic              clock = 1'b0;
   logic              reset;
   int                failures;
   int                backlog;
   int                cycles;
   bit                quiet;     // no idling on either side for this phase
   bit                hold_rsp;  // ask the reply side for one long hold-off
   logic [POOL_W-1:0] pool_now;  // last pool size written, to shape free indexes

   nfba_req_if req_chan ();
   nfba_rsp_if rsp_chan ();
   nfba_csr_if csr_chan ();

   next_fit_bitmap_slot_allocator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   nfba_reply_checker reply_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_operation    (req_chan.operation),
      .req_slot_index   (req_chan.slot_index),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_granted_slot (rsp_chan.granted_slot),
      .rsp_status       (rsp_chan.status),
      .csr_valid        (csr_chan.valid),
      .csr_ready        (csr_chan.ready),
      .csr_pool_size    (csr_chan.pool_size),
      .failures         (failures),
      .backlog          (backlog)
   );

   always #5 clock = ~clock;

   // Hard stop: a hung handshake ends here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Idle length: mostly none, often a few cycles, now and then a long gap.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Pool size for a random phase: the extremes first, then mostly small pools so
   // that the map fills, wraps and reports full.
   function automatic logic [POOL_W-1:0] pick_pool(input int phase);
      int r;
      case (phase)
         0: return POOL_RESET;
         1: return POOL_W'(1);
         2: return '0;
         3: return '1;
         4: return POOL_W'($urandom_range(SLOTS + 1, (1 << POOL_W) - 1));
         default: begin
            r = $urandom_range(0, 9);
            if (r < 5) return POOL_W'($urandom_range(2, 24));
            if (r < 8) return POOL_W'($urandom_range(25, 200));
            return POOL_W'($urandom_range(0, (1 << POOL_W) - 1));
         end
      endcase
   endfunction

   // Offer one request word and hold it until the block takes it. Valid is left
   // high on return so that back-to-back words need no extra edge.
   task automatic send_req(input logic op, input logic [SLOT_W-1:0] idx);
      int gap;
      gap = quiet ? 0 : gap_len();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.operation  <= op;
      req_chan.slot_index <= idx;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Drop the request valid and wait until every reply owed has come back.
   task automatic drain_replies();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (backlog != 0) @(posedge clock);
   endtask

   // Write the pool size once the block is idle.
   task automatic write_pool(input logic [POOL_W-1:0] value);
      drain_replies();
      csr_chan.valid     <= 1'b1;
      csr_chan.pool_size <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      pool_now = value;
   endtask

   // One random request. Frees land mostly inside the pool so that they hit
   // granted slots; the rest range over the whole index field or straddle the edge.
   task automatic send_random_item(input int alloc_pct);
      int                n;
      int                r;
      int                edge_idx;
      logic [SLOT_W-1:0] idx;
      n = (pool_now == 0) ? 1 : ((pool_now > SLOTS) ? SLOTS : int'(pool_now));
      if ($urandom_range(0, 99) < alloc_pct) begin
         send_req(OP_ALLOC, SLOT_W'($urandom));
      end else begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            idx = SLOT_W'($urandom_range(0, n - 1));
         end else if (r < 85) begin
            idx = SLOT_W'($urandom);
         end else begin
            edge_idx = n - 1 + $urandom_range(0, 2);
            idx = SLOT_W'((edge_idx > SLOTS - 1) ? SLOTS - 1 : edge_idx);
         end
         send_req(OP_FREE, idx);
      end
   endtask

   // Reply side: random stalls, one long hold-off on request, otherwise ready.
   initial begin : reply_drain
      int gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = quiet ? 0 : gap_len();
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin : stimulus
      int sent;
      int phase;
      int n_items;
      int alloc_pct;
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.operation  <= OP_ALLOC;
      req_chan.slot_index <= '0;
      csr_chan.valid      <= 1'b0;
      csr_chan.pool_size  <= '0;
      quiet    = 1'b0;
      hold_rsp = 1'b0;
      pool_now = POOL_RESET;
      sent     = 0;
      phase    = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset pool: first grants start at slot 0, free of a slot never granted,
      // both ends of the index field.
      send_req(OP_ALLOC, '0);
      send_req(OP_ALLOC, '1);
      send_req(OP_FREE, SLOT_W'(SLOTS - 1));
      send_req(OP_FREE, '0);
      send_req(OP_ALLOC, '0);

      // Four-slot pool: fill it, see full, free beyond the pool, then regrant.
      write_pool(POOL_W'(4));
      repeat (4) send_req(OP_ALLOC, '0);
      send_req(OP_FREE, SLOT_W'(4));
      send_req(OP_FREE, '1);
      send_req(OP_FREE, SLOT_W'(2));
      send_req(OP_ALLOC, '0);

      // Pool size zero acts as one slot; the last grant lies above it.
      write_pool('0);
      send_req(OP_ALLOC, '0);
      send_req(OP_ALLOC, '0);
      send_req(OP_FREE, SLOT_W'(1));
      send_req(OP_FREE, '0);
      send_req(OP_ALLOC, '0);

      // Oversized pool saturates to the full map.
      write_pool('1);
      send_req(OP_ALLOC, '0);
      send_req(OP_FREE, SLOT_W'(SLOTS - 1));

      // Grant up the pool, then shrink it under the last grant.
      write_pool(POOL_W'(12));
      repeat (3) send_req(OP_ALLOC, '0);
      write_pool(POOL_W'(3));
      send_req(OP_FREE, SLOT_W'(1));
      send_req(OP_ALLOC, '0);

      // Random phases, each under a fresh pool size.
      while (sent < RANDOM_ITEMS) begin
         write_pool(pick_pool(phase));
         quiet     = ($urandom_range(0, 3) == 0);
         alloc_pct = $urandom_range(35, 75);
         // Starve the reply side once while words keep coming.
         if (phase == 5) begin
            quiet    = 1'b1;
            hold_rsp = 1'b1;
         end
         n_items = $urandom_range(40, 80);
         repeat (n_items) begin
            send_random_item(alloc_pct);
            sent++;
         end
         phase++;
      end

      drain_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && backlog == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
